@@ hw/rtl/ssbsp_pkg.sv @@
package ssbsp_pkg;

  // Frequency cutoffs in NR-ARFCN units.
  localparam logic [19:0] CUTOFF_ABC        = 20'd600000;
  localparam logic [19:0] CUTOFF_C_UNPAIRED = 20'd376000;

  // A period of zero means the default of 5 ms.
  localparam logic [7:0] DEFAULT_PERIOD_MS = 8'd5;

  // Candidate pattern codes.
  localparam logic [1:0] CASE_A       = 2'd0;
  localparam logic [1:0] CASE_B       = 2'd1;
  localparam logic [1:0] CASE_C       = 2'd2;
  localparam logic [1:0] CASE_UNSUPP  = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 20;
  localparam logic [CFG_INDEX_W-1:0] REG_PERIOD_MS     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_NUMEROLOGY    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PRB_OFFSET    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CARRIER_ARFCN = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BURST_MASK    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_CASE  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_PAIRED        = 3'd6;

  // Remainder unit: 18 dividend bits, two bits per cycle.
  localparam int unsigned SLOT_W    = 18;
  localparam int unsigned DIV_STEPS = SLOT_W / 2;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // Depth of the descriptor queue between front and back.
  localparam int unsigned DQ_DEPTH = 2;
  localparam int unsigned DQ_PTR_W = (DQ_DEPTH > 1) ? $clog2(DQ_DEPTH) : 1;

  typedef struct packed {
    logic [17:0] slot_number;
    logic        list_full;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  block_index;
    logic [5:0]  first_symbol;
    logic [11:0] first_prb;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  period_ms;
    logic [2:0]  numerology;
    logic [11:0] prb_offset;
    logic [19:0] carrier_arfcn;
    logic [7:0]  burst_mask;
    logic [1:0]  pattern_case;
    logic        paired;
  } cfg_t;

  // One classified slot: its reduced slot (0 to 3) and which of its two
  // candidate blocks are sent.
  typedef struct packed {
    logic [1:0] slot;
    logic [1:0] emit;
  } desc_t;

  // First symbol of candidate n in reduced slot s.
  function automatic logic [5:0] first_sym(input logic case_b, input logic [1:0] s,
                                           input logic n);
    logic [5:0] s6;
    logic [5:0] e6;
    logic [5:0] sym;
    s6 = {4'd0, s};
    e6 = {4'd0, s[1], 1'b0};
    if (case_b) begin
      if (!s[0]) begin
        sym = 6'd4 + (s6 << 4) - (s6 << 1) + (n ? 6'd4 : 6'd0);
      end else begin
        sym = 6'd16 + (e6 << 4) - (e6 << 1) + (n ? 6'd4 : 6'd0);
      end
    end else begin
      sym = 6'd2 + (s6 << 4) - (s6 << 1) + (n ? 6'd6 : 6'd0);
    end
    return sym;
  endfunction

endpackage

@@ hw/rtl/ssbsp_front.sv @@
module ssbsp_front (
  input  logic              clk,
  input  logic              rst,
  input  ssbsp_pkg::cfg_t   cfg,
  input  logic              push,
  output logic              full,
  input  ssbsp_pkg::in_item_t in_item,
  output logic              wr_en,
  output ssbsp_pkg::desc_t  wr_data,
  input  logic              q_full
);
  import ssbsp_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]           state;
  logic [1:0]           state_next;
  logic [DIV_CNT_W-1:0] cnt;
  logic [SLOT_W-1:0]    quo;
  logic [7:0]           rem;
  logic [6:0]           low;
  logic                 drop;

  logic [7:0]  per;
  logic [6:0]  low_mask;
  logic [7:0]  rem_a;
  logic [7:0]  rem_b;
  logic [14:0] s_full;
  logic [19:0] cutoff;
  logic        send_ok;
  logic [2:0]  idx0;
  logic [2:0]  idx1;
  desc_t       desc;
  logic        push_ok;
  logic        accept;

  // One restoring step of the remainder.
  function automatic logic [7:0] rem_step(input logic [7:0] r, input logic b,
                                          input logic [7:0] d);
    logic [8:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
    end
    return t[7:0];
  endfunction

  // Period in ms; the low slot bits below the numerology pass straight into s.
  assign per      = (cfg.period_ms == 8'd0) ? DEFAULT_PERIOD_MS : cfg.period_ms;
  assign low_mask = 7'((8'd1 << cfg.numerology) - 8'd1);

  // Two remainder bits per cycle.
  assign rem_a = rem_step(rem, quo[SLOT_W-1], per);
  assign rem_b = rem_step(rem_a, quo[SLOT_W-2], per);

  // Classify the reduced slot once the remainder is complete.
  always_comb begin
    s_full  = (15'(rem) << cfg.numerology) | 15'(low);
    cutoff  = (cfg.pattern_case == CASE_C && !cfg.paired) ? CUTOFF_C_UNPAIRED
                                                            : CUTOFF_ABC;
    send_ok = !drop && (cfg.pattern_case != CASE_UNSUPP) && (s_full <= 15'd3) &&
              !((cfg.carrier_arfcn <= cutoff) && (s_full > 15'd1));
    idx0    = {s_full[1:0], 1'b0};
    idx1    = {s_full[1:0], 1'b1};
    desc.slot    = s_full[1:0];
    desc.emit[0] = send_ok && cfg.burst_mask[~idx0];
    desc.emit[1] = send_ok && cfg.burst_mask[~idx1];
  end

  // A slot with nothing to send leaves without touching the queue.
  assign push_ok = (desc.emit == 2'b00) || !q_full;
  assign wr_en   = (state == ST_DONE) && (desc.emit != 2'b00) && !q_full;
  assign wr_data = desc;
  assign full    = !((state == ST_IDLE) || ((state == ST_DONE) && push_ok));
  assign accept  = push && !full;

  // Sequencer state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (push_ok) state_next = accept ? ST_DIV : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        cnt <= '0;
      end else if (state == ST_DIV) begin
        cnt <= cnt + DIV_CNT_W'(1);
      end
    end
  end

  // Datapath of the remainder unit.
  always_ff @(posedge clk) begin
    if (accept) begin
      quo  <= in_item.slot_number >> cfg.numerology;
      rem  <= 8'd0;
      low  <= in_item.slot_number[6:0] & low_mask;
      drop <= in_item.list_full;
    end else if (state == ST_DIV) begin
      quo <= quo << 2;
      rem <= rem_b;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (cnt < DIV_CNT_W'(DIV_STEPS)))
    else $error("remainder step count out of range");

  a_push_nonempty: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> ((wr_data.emit != 2'b00) && (state == ST_DONE)))
    else $error("empty descriptor written to queue");

endmodule

@@ hw/rtl/ssbsp_dq.sv @@
module ssbsp_dq (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  ssbsp_pkg::desc_t wr_data,
  output logic             q_full,
  input  logic             rd_en,
  output ssbsp_pkg::desc_t rd_data,
  output logic             q_empty
);
  import ssbsp_pkg::*;

  desc_t               mem [DQ_DEPTH];
  logic [DQ_PTR_W-1:0] wptr;
  logic [DQ_PTR_W-1:0] rptr;
  logic [DQ_PTR_W:0]   count;

  assign q_full  = (count == (DQ_PTR_W + 1)'(DQ_DEPTH));
  assign q_empty = (count == '0);
  assign rd_data = mem[rptr];

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wptr <= (wptr == DQ_PTR_W'(DQ_DEPTH - 1)) ? '0 : wptr + DQ_PTR_W'(1);
      end
      if (rd_en) begin
        rptr <= (rptr == DQ_PTR_W'(DQ_DEPTH - 1)) ? '0 : rptr + DQ_PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + (DQ_PTR_W + 1)'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - (DQ_PTR_W + 1)'(1);
      end
    end
  end

  // Descriptor storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wptr] <= wr_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !q_full)
    else $error("descriptor queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> !q_empty)
    else $error("descriptor queue underflow");

endmodule

@@ hw/rtl/ssbsp_back.sv @@
module ssbsp_back (
  input  logic                clk,
  input  logic                rst,
  input  ssbsp_pkg::cfg_t     cfg,
  output logic                rd_en,
  input  ssbsp_pkg::desc_t    rd_data,
  input  logic                q_empty,
  output logic                empty,
  input  logic                pop,
  output ssbsp_pkg::out_item_t out_item
);
  import ssbsp_pkg::*;

  logic       ovalid;
  logic [1:0] pend;
  logic [1:0] slot;
  logic       adv;
  logic       issue;
  logic       sel_n;
  logic [1:0] pend_after;
  logic       take;
  out_item_t  res;

  // The output register can take a new result when it is free or being popped.
  assign adv        = !ovalid || pop;
  assign issue      = adv && (pend != 2'b00);
  assign sel_n      = !pend[0];
  assign pend_after = issue ? (pend & ~(2'b01 << sel_n)) : pend;
  assign take       = !q_empty && (pend_after == 2'b00);
  assign rd_en      = take;
  assign empty      = !ovalid;

  // Build the result for the lowest pending candidate.
  always_comb begin
    res.block_index  = {slot, sel_n};
    res.first_symbol = first_sym(cfg.pattern_case == CASE_B, slot, sel_n);
    res.first_prb    = cfg.prb_offset;
    res.last         = (pend_after == 2'b00);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
      pend   <= 2'b00;
    end else begin
      pend <= take ? rd_data.emit : pend_after;
      if (issue) begin
        ovalid <= 1'b1;
      end else if (pop) begin
        ovalid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (take) begin
      slot <= rd_data.slot;
    end
    if (issue) begin
      out_item <= res;
    end
  end

  a_more_pending: assert property (@(posedge clk) disable iff (rst)
    (ovalid && !out_item.last) |-> (pend != 2'b00))
    else $error("result not marked last but nothing pending");

endmodule

@@ hw/rtl/ssb_slot_placement.sv @@
// Channel   Handshake        Payload              Notes
// input     push / full      in_item_t            one slot number per transfer
// result    empty / pop      out_item_t           zero to two blocks per slot
// config    cfg_we           cfg_index, cfg_data  write only, no wait
//
// The front reduces each slot with an iterative remainder unit that retires two
// dividend bits per cycle; the next item is accepted in the cycle the previous
// one is classified, unless its descriptor finds the queue full. Results leave
// the back at one per cycle unless pop stalls, via a registered output stage.
// Reset is synchronous and clears all control state and the registers
// (paired resets to 1). A stalled result side backs up through the descriptor
// queue to full; the front keeps working until the queue is full.
module ssb_slot_placement (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  ssbsp_pkg::in_item_t                  in_item,
  output logic                                 empty,
  input  logic                                 pop,
  output ssbsp_pkg::out_item_t                 out_item,
  input  logic                                 cfg_we,
  input  logic [ssbsp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ssbsp_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ssbsp_pkg::*;

  cfg_t  cfg;
  logic  wr_en;
  desc_t wr_data;
  logic  q_full;
  logic  rd_en;
  desc_t rd_data;
  logic  q_empty;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period_ms     <= 8'd0;
      cfg.numerology    <= 3'd0;
      cfg.prb_offset    <= 12'd0;
      cfg.carrier_arfcn <= 20'd0;
      cfg.burst_mask    <= 8'd0;
      cfg.pattern_case  <= CASE_A;
      cfg.paired        <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PERIOD_MS:     cfg.period_ms     <= cfg_data[7:0];
        REG_NUMEROLOGY:    cfg.numerology    <= cfg_data[2:0];
        REG_PRB_OFFSET:    cfg.prb_offset    <= cfg_data[11:0];
        REG_CARRIER_ARFCN: cfg.carrier_arfcn <= cfg_data[19:0];
        REG_BURST_MASK:    cfg.burst_mask    <= cfg_data[7:0];
        REG_PATTERN_CASE:  cfg.pattern_case  <= cfg_data[1:0];
        REG_PAIRED:        cfg.paired        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Front: accept, reduce and classify.
  ssbsp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .wr_en   (wr_en),
    .wr_data (wr_data),
    .q_full  (q_full)
  );

  // Descriptor queue between the two sides.
  ssbsp_dq u_dq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_data (wr_data),
    .q_full  (q_full),
    .rd_en   (rd_en),
    .rd_data (rd_data),
    .q_empty (q_empty)
  );

  // Back: expand descriptors into result transfers.
  ssbsp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .rd_en    (rd_en),
    .rd_data  (rd_data),
    .q_empty  (q_empty),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule
